@@ rtl/core/iee_pkg.sv @@
// Shared types, the table of equivalent-encoding patterns and the compare helpers
// for the encoding equivalence checker. Depends on nothing; the cell and top-level files import it.
package iee_pkg;

  localparam int CellCount = 16;
  localparam int WinBytes  = 10;

  localparam logic [3:0] MaxLeft  = 4'd8;
  localparam logic [7:0] FullMask = 8'hff;
  localparam logic [7:0] ModRmMask = 8'hc0;
  localparam logic [3:0] NoPos    = 4'd8;

  // Pattern table. Byte j of a pattern sits in bits 8j+7:8j.
  localparam logic [3:0] RomLen [CellCount] = '{
    4'd4, 4'd3, 4'd4, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2,
    4'd2, 4'd4, 4'd5, 4'd8, 4'd2, 4'd2, 4'd3, 4'd3};

  // Window index of the pattern's first byte (offset plus three).
  localparam logic [1:0] RomBase [CellCount] = '{
    2'd2, 2'd1, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd3,
    2'd3, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd1};

  // Bytes to advance on a match: length plus offset.
  localparam logic [2:0] RomSkip [CellCount] = '{
    3'd3, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd7, 3'd1, 3'd2, 3'd3, 3'd1};

  // Bit i set when entry i swaps reg and rm on mod/rm bytes.
  localparam logic [CellCount-1:0] RomSwap   = 16'b1000_0000_0111_1110;
  // Bit i set when entry i matches as soon as both masks agree.
  localparam logic [CellCount-1:0] RomSimple = 16'b0110_0000_0000_0000;

  localparam logic [63:0] RomAVal [CellCount] = '{
    64'h0000_0000_03f8_8366, 64'h0000_0000_0003_748d,
    64'h0000_0000_0884_b60f, 64'h0000_0000_0003_4cfe,
    64'h0000_0000_000c_0c38, 64'h0000_0000_0000_d384,
    64'h0000_0000_0000_ca3a, 64'h0000_0000_0000_66f3,
    64'h0000_0000_0000_c0d8, 64'h0000_0000_9024_0400,
    64'h0000_0090_0024_0400, 64'h9000_0000_0024_0400,
    64'h0000_0000_0000_ff8b, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0006_44f6};

  localparam logic [63:0] RomAMsk [CellCount] = '{
    64'h0000_0000_00ff_ffff, 64'h0000_0000_00c0_07f0,
    64'h0000_0000_c007_ffff, 64'h0000_0000_00c0_fffe,
    64'h0000_0000_00c0_ffff, 64'h0000_0000_0000_c0fe,
    64'h0000_0000_0000_c0ff, 64'h0000_0000_0000_fffe,
    64'h0000_0000_0000_f7ff, 64'h0000_0000_ffff_c700,
    64'h0000_00ff_00ff_c700, 64'hff00_0000_00ff_c700,
    64'h0000_0000_0000_ffff, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0050, 64'h0000_0000_00c0_0700};

  localparam logic [63:0] RomBVal [CellCount] = '{
    64'h0000_0000_0003_3d66, 64'h0000_0000_0018_748d,
    64'h0000_0000_0184_b60f, 64'h0000_0000_0018_4cfe,
    64'h0000_0000_0030_0c38, 64'h0000_0000_0000_da84,
    64'h0000_0000_0000_d138, 64'h0000_0000_0000_f366,
    64'h0000_0000_0000_c0dc, 64'h0000_0000_0024_4400,
    64'h0000_0000_0024_4400, 64'h0000_0000_0024_4400,
    64'h0000_0000_0000_c08b, 64'h0000_0000_0000_c08b,
    64'h0000_0000_00c0_8b2e, 64'h0000_0000_0030_44f6};

  localparam logic [63:0] RomBMsk [CellCount] = '{
    64'h0000_0000_ff00_ffff, 64'h0000_0000_00c0_07f0,
    64'h0000_0000_c007_ffff, 64'h0000_0000_00c0_fffe,
    64'h0000_0000_00c0_ffff, 64'h0000_0000_0000_c0fe,
    64'h0000_0000_0000_c0ff, 64'h0000_0000_0000_feff,
    64'h0000_0000_0000_f7ff, 64'h0000_0000_ffff_c700,
    64'h0000_0000_ffff_c700, 64'h0000_0000_ffff_c700,
    64'h0000_0000_0000_ffff, 64'h0000_0000_0000_ffff,
    64'h0000_0000_00ff_ffff, 64'h0000_0000_00c0_0700};

  // One word as it moves from cell to cell.
  typedef struct packed {
    logic                  valid;
    logic [8*WinBytes-1:0] win_a;
    logic [8*WinBytes-1:0] win_b;
    logic [3:0]            left;
    logic                  decided;
    logic                  matched;
    logic [2:0]            skip;
    logic [3:0]            hit;
  } iee_stage_t;

  // Byte of a window, padded with zeros past its end.
  function automatic logic [7:0] byte_at(input logic [8*WinBytes-1:0] win,
                                         input logic [3:0] pos);
    logic [127:0] padded;
    padded = {{(128 - 8*WinBytes){1'b0}}, win};
    return padded[8*pos +: 8];
  endfunction

  // Position of the k-th byte that the mask does not fully cover, or NoPos.
  function automatic logic [3:0] nth_free(input logic [63:0] msk, input logic [3:0] len,
                                          input logic [2:0] k);
    logic [3:0] pos;
    logic [3:0] cnt;
    pos = NoPos;
    cnt = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < len && msk[8*i +: 8] != FullMask) begin
        if (cnt == {1'b0, k} && pos == NoPos) begin
          pos = 4'(i);
        end
        cnt = cnt + 4'd1;
      end
    end
    return pos;
  endfunction

  // True when the window equals the pattern under the mask over the entry length.
  function automatic logic masked_ok(input logic [8*WinBytes-1:0] win,
                                     input logic [1:0] base, input logic [3:0] len,
                                     input logic [63:0] val, input logic [63:0] msk);
    logic ok;
    logic [7:0] m;
    ok = 1'b1;
    for (int i = 0; i < 8; i++) begin
      m = msk[8*i +: 8];
      if (4'(i) < len &&
          (byte_at(win, {2'b00, base} + 4'(i)) & m) != (val[8*i +: 8] & m)) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Pairs the free bytes of both windows in order; true when both have equally many and every pair agrees.
  function automatic logic pair_ok(input logic [3:0] idx,
                                   input logic [8*WinBytes-1:0] win_a,
                                   input logic [8*WinBytes-1:0] win_b);
    logic       ok;
    logic [3:0] pa;
    logic [3:0] pb;
    logic [7:0] ma;
    logic [7:0] mb;
    logic [7:0] va;
    logic [7:0] vb;
    ok = 1'b1;
    for (int k = 0; k < 8; k++) begin
      pa = nth_free(RomAMsk[idx], RomLen[idx], 3'(k));
      pb = nth_free(RomBMsk[idx], RomLen[idx], 3'(k));
      if (pa[3] != pb[3]) begin
        ok = 1'b0;
      end else if (!pa[3]) begin
        ma = RomAMsk[idx][8*pa[2:0] +: 8];
        mb = RomBMsk[idx][8*pb[2:0] +: 8];
        va = byte_at(win_a, {2'b00, RomBase[idx]} + pa) & ~ma;
        vb = byte_at(win_b, {2'b00, RomBase[idx]} + pb) & ~mb;
        if (RomSwap[idx] && ma == ModRmMask) begin
          if ((va & 8'h07) != (vb >> 3) || (va >> 3) != (vb & 8'h07)) begin
            ok = 1'b0;
          end
        end else if (va != vb) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

@@ rtl/core/iee_if.sv @@
// Channel interfaces of the encoding equivalence checker: the window word going in
// and the verdict word coming out. No dependencies.
interface iee_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] first_before;
  logic [55:0] first_ahead;
  logic [23:0] second_before;
  logic [55:0] second_ahead;
  logic [3:0]  bytes_left;

  modport source (output valid, first_before, first_ahead, second_before, second_ahead,
                  bytes_left, input ready);
  modport sink (input valid, first_before, first_ahead, second_before, second_ahead,
                bytes_left, output ready);
endinterface

interface iee_out_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic [2:0] skip_length;
  logic [3:0] entry_hit;

  modport source (output valid, matched, skip_length, entry_hit, input ready);
  modport sink (input valid, matched, skip_length, entry_hit, output ready);
endinterface

@@ rtl/core/iee_cell.sv @@
// One cell of the checker chain: tests a word against a single table entry and
// registers it for the next cell. Depends on iee_pkg.
module iee_cell import iee_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [3:0] cell_idx,
  input  iee_stage_t stage_i,
  output iee_stage_t stage_o
);

  iee_stage_t stage_r;
  iee_stage_t stage_nxt;
  logic       applies;
  logic       equal;

  assign applies = (stage_i.left >= RomLen[cell_idx]) &&
                   masked_ok(stage_i.win_a, RomBase[cell_idx], RomLen[cell_idx],
                             RomAVal[cell_idx], RomAMsk[cell_idx]) &&
                   masked_ok(stage_i.win_b, RomBase[cell_idx], RomLen[cell_idx],
                             RomBVal[cell_idx], RomBMsk[cell_idx]);

  assign equal = RomSimple[cell_idx] || pair_ok(cell_idx, stage_i.win_a, stage_i.win_b);

  // An earlier entry that applied keeps its verdict.
  always_comb begin
    stage_nxt = stage_i;
    if (!stage_i.decided && applies) begin
      stage_nxt.decided = 1'b1;
      stage_nxt.hit     = cell_idx;
      stage_nxt.matched = equal;
      stage_nxt.skip    = equal ? RomSkip[cell_idx] : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (advance) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

@@ rtl/core/instruction_encoding_equivalence.sv @@
// Top level of the x86 encoding equivalence checker: a chain of sixteen pattern cells.
// Depends on iee_pkg, iee_in_if / iee_out_if and iee_cell.
//
// Usage. Each input word carries two ten-byte code windows taken at the first
// point where two encoders disagree (three bytes before that point and seven from
// it) plus the number of bytes left from the point; values above eight count as
// eight. The output word says whether the deciding table entry found the two
// encodings equivalent, how many bytes to skip, and which entry decided.
// Both channels use valid/ready; a word moves when both are high.
//
// Pipeline. Every cell owns one table entry and one register stage, so a word
// passes the register stage of every cell before it leaves the sixteenth cell,
// and the chain takes one word per cycle while the output is not stalled. The
// rate is set by the single register step per cell; the depth by the table entries.
//
// Stalls. When a word waits at the output and ready is low, the whole chain holds
// and in_chan.ready drops in the same cycle; it rises again as soon as the
// output word is taken. Reset clears every stage's valid flag, so the output
// shows no word until the first accepted word has passed all cells.
module instruction_encoding_equivalence import iee_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  iee_in_if.sink    in_chan,
  iee_out_if.source out_chan
);

  iee_stage_t chain_link [CellCount+1];
  logic       advance;

  // The chain moves when its last stage is empty or being emptied.
  assign advance = !chain_link[CellCount].valid || out_chan.ready;
  assign in_chan.ready = advance;

  // Build the word entering the first cell; no entry has decided yet.
  always_comb begin
    chain_link[0].valid   = in_chan.valid;
    chain_link[0].win_a   = {in_chan.first_ahead, in_chan.first_before};
    chain_link[0].win_b   = {in_chan.second_ahead, in_chan.second_before};
    chain_link[0].left    = (in_chan.bytes_left > MaxLeft) ? MaxLeft : in_chan.bytes_left;
    chain_link[0].decided = 1'b0;
    chain_link[0].matched = 1'b0;
    chain_link[0].skip    = 3'd0;
    chain_link[0].hit     = 4'd0;
  end

  // Cell g tests table entry g; the first entry that applies fixes the verdict.
  for (genvar g = 0; g < CellCount; g++) begin : g_cell
    iee_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .cell_idx (4'(g)),
      .stage_i  (chain_link[g]),
      .stage_o  (chain_link[g+1])
    );
  end

  assign out_chan.valid       = chain_link[CellCount].valid;
  assign out_chan.matched     = chain_link[CellCount].matched;
  assign out_chan.skip_length = chain_link[CellCount].skip;
  assign out_chan.entry_hit   = chain_link[CellCount].hit;

  // Every table entry advances at least one byte, so a match never skips zero.
  a_match_skips : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.matched |-> out_chan.skip_length != 3'd0)
    else $error("matched word with zero skip length");

  // A mismatch never advances.
  a_miss_no_skip : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.matched |-> out_chan.skip_length == 3'd0)
    else $error("unmatched word with nonzero skip length");

  // The first entry spans four bytes starting one byte back.
  a_entry0_skip : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.matched && out_chan.entry_hit == 4'd0
      |-> out_chan.skip_length == 3'd3)
    else $error("first entry matched with wrong skip length");

  // An accepted word always lands in the first cell's register.
  a_accept_lands : assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> chain_link[1].valid)
    else $error("accepted word lost at chain entry");

endmodule
